// ===== rtl/core/gdps_pkg.sv =====
package gdps_pkg;

    // Field and datapath widths.
    localparam int COORD_W = 8;
    localparam int PEAK_W  = 11;
    localparam int BLUR_W  = 8;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int R2_W    = SQ_W + 1;
    localparam int NUM_W   = PEAK_W + BLUR_W;
    localparam int DEN_W   = R2_W + 1;
    localparam int LEVEL_W = 9;
    localparam int CHAN_W  = 8;
    localparam int DIV_W   = DEN_W + LEVEL_W;

    // Register index of blur_width in the configuration space.
    localparam int REG_BLUR_WIDTH = 0;

    // Level and channel limits.
    localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 9'd511;
    localparam logic [CHAN_W-1:0]  CHANNEL_FULL = 8'd255;
    localparam logic [BLUR_W-1:0]  BLUR_RESET   = 8'd16;

    // One slot of the divider pipeline.
    typedef struct packed {
        logic               valid;
        logic [NUM_W-1:0]   rem;
        logic [DEN_W-1:0]   den;
        logic [LEVEL_W-1:0] quo;
        logic               bypass;
        logic [LEVEL_W-1:0] byp_level;
    } t_div_item;

endpackage

// ===== rtl/core/gdps_div_step.sv =====
module gdps_div_step #(
    parameter int BIT_POS = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gdps_pkg::t_div_item i_item,
    output gdps_pkg::t_div_item o_item
);
    import gdps_pkg::*;

    t_div_item        r_item;
    t_div_item        n_item;
    logic [DIV_W-1:0] w_shifted;
    logic [DIV_W-1:0] w_rem_ext;

    // Restoring division: try to subtract the divisor at this quotient weight.
    always_comb begin
        w_shifted = DIV_W'(i_item.den) << BIT_POS;
        w_rem_ext = DIV_W'(i_item.rem);
        n_item    = i_item;
        if (w_rem_ext >= w_shifted) begin
            n_item.rem          = NUM_W'(w_rem_ext - w_shifted);
            n_item.quo[BIT_POS] = 1'b1;
        end
    end

    // Stage register; the valid bit travels with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// ===== rtl/core/glow_dot_pixel_shader_unit.sv =====
// Channel     | Direction | Signals                                  | Transaction
// ------------+-----------+------------------------------------------+-------------------------
// pixel in    | input     | start, busy, i_pixel_x/y, i_dot_x/y,     | start high, busy low
//             |           | i_peak_level                             |
// color out   | output    | o_valid, o_red, o_green, o_blue          | o_valid high, one cycle
// config      | APB       | psel, penable, pwrite, paddr, pwdata,    | psel, penable, pwrite
//             |           | prdata, pready                           | and pready high
//
// One pixel is accepted every clock; busy is always low.
// After its pixel is accepted, a color passes through four front stages
// (distance, squares and product, denominator, saturation check), nine
// divider stages of one quotient bit each, and the output register.
// Synchronous active-low reset clears the valid bits and sets blur_width to 16.
// The receiver cannot stall, so the pipeline never holds.
module glow_dot_pixel_shader_unit #(
    parameter int MATRIX_WIDTH  = 256,
    parameter int MATRIX_HEIGHT = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Pixel input.
    input  logic                          start,
    output logic                          busy,
    input  logic [gdps_pkg::COORD_W-1:0]  i_pixel_x,
    input  logic [gdps_pkg::COORD_W-1:0]  i_pixel_y,
    input  logic [gdps_pkg::COORD_W-1:0]  i_dot_x,
    input  logic [gdps_pkg::COORD_W-1:0]  i_dot_y,
    input  logic [gdps_pkg::PEAK_W-1:0]   i_peak_level,
    // Color output.
    output logic                          o_valid,
    output logic [gdps_pkg::CHAN_W-1:0]   o_red,
    output logic [gdps_pkg::CHAN_W-1:0]   o_green,
    output logic [gdps_pkg::CHAN_W-1:0]   o_blue,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import gdps_pkg::*;

    localparam logic [COORD_W-1:0] X_TOP = COORD_W'(MATRIX_WIDTH - 1);
    localparam logic [COORD_W-1:0] Y_TOP = COORD_W'(MATRIX_HEIGHT - 1);

    // Configuration register.
    logic [BLUR_W-1:0] r_blur;
    logic              w_reg_idx;

    assign w_reg_idx = paddr[2];
    assign pready    = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blur <= BLUR_RESET;
        end else if (psel && penable && pwrite && (w_reg_idx == 1'(REG_BLUR_WIDTH))) begin
            r_blur <= pwdata[BLUR_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_reg_idx == 1'(REG_BLUR_WIDTH)) begin
            prdata = 32'(r_blur);
        end
    end

    // Stage 1: clamp the dot and take the absolute offsets.
    logic [COORD_W-1:0] w_dx;
    logic [COORD_W-1:0] w_dy;
    logic [COORD_W-1:0] n_s1_ex;
    logic [COORD_W-1:0] n_s1_ey;
    logic               r_s1_valid;
    logic [COORD_W-1:0] r_s1_ex;
    logic [COORD_W-1:0] r_s1_ey;
    logic [PEAK_W-1:0]  r_s1_peak;

    always_comb begin
        w_dx    = (i_dot_x > X_TOP) ? X_TOP : i_dot_x;
        w_dy    = (i_dot_y > Y_TOP) ? Y_TOP : i_dot_y;
        n_s1_ex = (i_pixel_x >= w_dx) ? i_pixel_x - w_dx : w_dx - i_pixel_x;
        n_s1_ey = (i_pixel_y >= w_dy) ? i_pixel_y - w_dy : w_dy - i_pixel_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_ex   <= n_s1_ex;
        r_s1_ey   <= n_s1_ey;
        r_s1_peak <= i_peak_level;
    end

    // Stage 2: squares of the offsets and the numerator peak * blur.
    logic              r_s2_valid;
    logic [SQ_W-1:0]   r_s2_sqx;
    logic [SQ_W-1:0]   r_s2_sqy;
    logic [NUM_W-1:0]  r_s2_num;
    logic [PEAK_W-1:0] r_s2_peak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_sqx  <= SQ_W'(r_s1_ex) * SQ_W'(r_s1_ex);
        r_s2_sqy  <= SQ_W'(r_s1_ey) * SQ_W'(r_s1_ey);
        r_s2_num  <= NUM_W'(r_s1_peak) * NUM_W'(r_blur);
        r_s2_peak <= r_s1_peak;
    end

    // Stage 3: squared distance and denominator r2 + blur - 1.
    logic [R2_W-1:0]   w_r2;
    logic              r_s3_valid;
    logic              r_s3_r2zero;
    logic [DEN_W-1:0]  r_s3_den;
    logic [NUM_W-1:0]  r_s3_num;
    logic [PEAK_W-1:0] r_s3_peak;

    assign w_r2 = R2_W'(r_s2_sqx) + R2_W'(r_s2_sqy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_r2zero <= (w_r2 == '0);
        r_s3_den    <= DEN_W'(w_r2) + DEN_W'(r_blur) - DEN_W'(1);
        r_s3_num    <= r_s2_num;
        r_s3_peak   <= r_s2_peak;
    end

    // Stage 4: settle the cases that skip the divider.
    logic      w_sat;
    t_div_item n_s4;
    t_div_item r_s4;

    always_comb begin
        w_sat          = DIV_W'(r_s3_num) >= (DIV_W'(r_s3_den) << LEVEL_W);
        n_s4.valid     = r_s3_valid;
        n_s4.rem       = r_s3_num;
        n_s4.den       = r_s3_den;
        n_s4.quo       = '0;
        n_s4.bypass    = 1'b1;
        n_s4.byp_level = '0;
        if (r_s3_r2zero) begin
            // At the dot centre the level is the peak itself, capped at LEVEL_MAX.
            n_s4.byp_level = (r_s3_peak > PEAK_W'(LEVEL_MAX)) ? LEVEL_MAX
                                                                : r_s3_peak[LEVEL_W-1:0];
        end else if (r_s3_den == '0) begin
            n_s4.byp_level = '0;
        end else if (w_sat) begin
            n_s4.byp_level = LEVEL_MAX;
        end else begin
            n_s4.bypass = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4.valid <= 1'b0;
        end else begin
            r_s4 <= n_s4;
        end
    end

    // Divider: one quotient bit per stage, most significant first.
    t_div_item w_div [LEVEL_W+1];

    assign w_div[0] = r_s4;

    for (genvar g = 0; g < LEVEL_W; g++) begin : g_div
        gdps_div_step #(
            .BIT_POS (LEVEL_W - 1 - g)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_item  (w_div[g]),
            .o_item  (w_div[g+1])
        );
    end

    // Output stage: map the level to a color.
    t_div_item          w_last;
    logic [LEVEL_W-1:0] w_level;
    logic               r_o_valid;
    logic [CHAN_W-1:0]  r_red;
    logic [CHAN_W-1:0]  r_gb;

    assign w_last  = w_div[LEVEL_W];
    assign w_level = w_last.bypass ? w_last.byp_level : w_last.quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= w_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_level[LEVEL_W-1]) begin
            r_red <= CHANNEL_FULL;
            r_gb  <= w_level[CHAN_W-1:0];
        end else begin
            r_red <= w_level[CHAN_W-1:0];
            r_gb  <= '0;
        end
    end

    assign o_valid = r_o_valid;
    assign o_red   = r_red;
    assign o_green = r_gb;
    assign o_blue  = r_gb;

endmodule

// ===== bench/gdps_color_checker.sv =====
`timescale 1ns / 100ps

// Watches the pixel, color and configuration channels of the glow dot shader,
// predicts each color from the accepted pixel and compares it in order.
module gdps_color_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic [gdps_pkg::COORD_W-1:0]  i_pixel_x,
    input  logic [gdps_pkg::COORD_W-1:0]  i_pixel_y,
    input  logic [gdps_pkg::COORD_W-1:0]  i_dot_x,
    input  logic [gdps_pkg::COORD_W-1:0]  i_dot_y,
    input  logic [gdps_pkg::PEAK_W-1:0]   i_peak_level,
    input  logic                          i_valid,
    input  logic [gdps_pkg::CHAN_W-1:0]   i_red,
    input  logic [gdps_pkg::CHAN_W-1:0]   i_green,
    input  logic [gdps_pkg::CHAN_W-1:0]   i_blue,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [2:0]                    i_paddr,
    input  logic [31:0]                   i_pwdata,
    input  logic [31:0]                   i_prdata,
    input  logic                          i_pready,
    output int                            o_mismatch_count,
    output int                            o_colors_pending
);

    import gdps_pkg::*;

    localparam int MATRIX_W   = 256;
    localparam int MATRIX_H   = 256;
    localparam int LEVEL_HALF = 256;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_color;

    t_color            expected_colors[$];
    logic [BLUR_W-1:0] blur_width_shadow;
    int                mismatches;

    assign o_mismatch_count = mismatches;
    assign o_colors_pending = expected_colors.size();

    initial begin
        mismatches        = 0;
        blur_width_shadow = BLUR_RESET;
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("t=%0t %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Glow falloff: peak at the center, peak*blur/(r2+blur-1) elsewhere, saturated.
    function automatic t_color shade_pixel(
        input logic [COORD_W-1:0] px,
        input logic [COORD_W-1:0] py,
        input logic [COORD_W-1:0] dot_x,
        input logic [COORD_W-1:0] dot_y,
        input logic [PEAK_W-1:0]  peak,
        input logic [BLUR_W-1:0]  blur
    );
        int unsigned cx, cy, ex, ey, r2, num, den, level;
        t_color      c;
        // The dot is kept inside the matrix; the pixel is used as given.
        cx = (32'(dot_x) > MATRIX_W - 1) ? MATRIX_W - 1 : 32'(dot_x);
        cy = (32'(dot_y) > MATRIX_H - 1) ? MATRIX_H - 1 : 32'(dot_y);
        ex = (32'(px) >= cx) ? 32'(px) - cx : cx - 32'(px);
        ey = (32'(py) >= cy) ? 32'(py) - cy : cy - 32'(py);
        r2 = ex * ex + ey * ey;
        if (r2 == 0) begin
            level = 32'(peak);
        end else begin
            num   = 32'(peak) * 32'(blur);
            den   = r2 + 32'(blur) - 1;
            level = (den == 0) ? 0 : num / den;
        end
        if (level > 32'(LEVEL_MAX)) level = 32'(LEVEL_MAX);
        if (level < LEVEL_HALF) begin
            c.red   = CHAN_W'(level);
            c.green = '0;
        end else begin
            c.red   = CHANNEL_FULL;
            c.green = CHAN_W'(level - LEVEL_HALF);
        end
        c.blue = c.green;
        return c;
    endfunction

    // Sample every channel at the rising edge that completes its transaction.
    always @(posedge i_clk) begin
        t_color want;
        if (!i_rst_n) begin
            blur_width_shadow = BLUR_RESET;
            expected_colors.delete();
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (int'(i_paddr >> 2) == REG_BLUR_WIDTH)
                        blur_width_shadow = i_pwdata[BLUR_W-1:0];
                end else if (int'(i_paddr >> 2) == REG_BLUR_WIDTH) begin
                    if (i_prdata !== 32'(blur_width_shadow))
                        report_mismatch("blur_width readback", int'(i_prdata),
                                        int'(blur_width_shadow));
                end
            end
            // A color leaving now belongs to a pixel accepted well before this edge.
            if (i_valid) begin
                if (expected_colors.size() == 0) begin
                    report_mismatch("color with no pixel pending", int'(i_red), -1);
                end else begin
                    want = expected_colors.pop_front();
                    if (i_red !== want.red)
                        report_mismatch("red", int'(i_red), int'(want.red));
                    if (i_green !== want.green)
                        report_mismatch("green", int'(i_green), int'(want.green));
                    if (i_blue !== want.blue)
                        report_mismatch("blue", int'(i_blue), int'(want.blue));
                end
            end
            if (i_start && !i_busy)
                expected_colors.push_back(shade_pixel(i_pixel_x, i_pixel_y, i_dot_x, i_dot_y,
                                                      i_peak_level, blur_width_shadow));
        end
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

// Drives pixels and register writes into the shader and gives the verdict.
module testbench;

    import gdps_pkg::*;

    localparam logic [2:0] ADDR_BLUR_WIDTH = 3'd0;
    localparam logic [2:0] ADDR_UNUSED     = 3'd4;
    localparam int         WATCHDOG_LIMIT  = 2000;
    localparam int         IDLE_PERCENT    = 29;
    localparam int         PHASE_ITEMS     = 190;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [COORD_W-1:0]   pixel_x, pixel_y, dot_x, dot_y;
    logic [PEAK_W-1:0]    peak_level;
    logic                 o_valid;
    logic [CHAN_W-1:0]    o_red, o_green, o_blue;
    logic                 psel, penable, pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    int                   mismatch_count;
    int                   colors_pending;
    int                   quiet_cycles;
    bit                   idle_on;

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    glow_dot_pixel_shader_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_pixel_x    (pixel_x),
        .i_pixel_y    (pixel_y),
        .i_dot_x      (dot_x),
        .i_dot_y      (dot_y),
        .i_peak_level (peak_level),
        .o_valid      (o_valid),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    gdps_color_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_pixel_x        (pixel_x),
        .i_pixel_y        (pixel_y),
        .i_dot_x          (dot_x),
        .i_dot_y          (dot_y),
        .i_peak_level     (peak_level),
        .i_valid          (o_valid),
        .i_red            (o_red),
        .i_green          (o_green),
        .i_blue           (o_blue),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .i_prdata         (prdata),
        .i_pready         (pready),
        .o_mismatch_count (mismatch_count),
        .o_colors_pending (colors_pending)
    );

    // Ends the run when no transaction of any kind completes for too long.
    initial quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (psel && penable && pready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("glow_dot_pixel_shader_unit: mismatch");
            $finish;
        end
    end

    // One pixel transaction, with random idle cycles in front of it.
    task automatic send_pixel(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                              input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                              input logic [PEAK_W-1:0] peak);
        while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start      = 1'b1;
        pixel_x    = px;
        pixel_y    = py;
        dot_x      = cx;
        dot_y      = cy;
        peak_level = peak;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // APB transfer: setup cycle, then access until pready.
    task automatic apb_transfer(input logic write, input logic [2:0] addr,
                                input logic [31:0] data);
        @(negedge i_clk);
        start   = 1'b0;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = write;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Lets the pipeline empty before the register changes.
    task automatic drain_colors();
        @(negedge i_clk);
        start = 1'b0;
        while (colors_pending != 0) @(posedge i_clk);
    endtask

    task automatic set_blur_width(input logic [31:0] value);
        drain_colors();
        apb_transfer(1'b1, ADDR_BLUR_WIDTH, value);
        apb_transfer(1'b0, ADDR_BLUR_WIDTH, $urandom);
    endtask

    // Mostly pixels near the dot, where the falloff is interesting.
    task automatic run_random(input int count);
        logic [COORD_W-1:0] px, py, cx, cy;
        logic [PEAK_W-1:0]  peak;
        int                 kind;
        for (int n = 0; n < count; n++) begin
            cx   = COORD_W'($urandom_range(0, 255));
            cy   = COORD_W'($urandom_range(0, 255));
            kind = $urandom_range(99);
            if (kind < 40) begin
                px = COORD_W'(cx + $urandom_range(0, 6) - 3);
                py = COORD_W'(cy + $urandom_range(0, 6) - 3);
            end else if (kind < 70) begin
                px = COORD_W'(cx + $urandom_range(0, 32) - 16);
                py = COORD_W'(cy + $urandom_range(0, 32) - 16);
            end else begin
                px = COORD_W'($urandom_range(0, 255));
                py = COORD_W'($urandom_range(0, 255));
            end
            if ($urandom_range(99) < 60)
                peak = PEAK_W'($urandom_range(0, 2047));
            else
                peak = PEAK_W'($urandom_range(0, 600));
            send_pixel(px, py, cx, cy, peak);
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        start      = 1'b0;
        pixel_x    = '0;
        pixel_y    = '0;
        dot_x      = '0;
        dot_y      = '0;
        peak_level = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        idle_on    = 1'b1;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset value of blur_width, then directed pixels at that setting.
        apb_transfer(1'b0, ADDR_BLUR_WIDTH, '0);
        send_pixel(8'd10, 8'd10, 8'd10, 8'd10, 11'd0);
        send_pixel(8'd10, 8'd10, 8'd10, 8'd10, 11'd255);
        send_pixel(8'd10, 8'd10, 8'd10, 8'd10, 11'd256);
        send_pixel(8'd10, 8'd10, 8'd10, 8'd10, 11'd511);
        send_pixel(8'd10, 8'd10, 8'd10, 8'd10, 11'd512);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 11'd2047);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 11'd300);
        send_pixel(8'd0, 8'd0, 8'd255, 8'd255, 11'd2047);
        send_pixel(8'd255, 8'd255, 8'd0, 8'd0, 11'd2047);
        send_pixel(8'd11, 8'd10, 8'd10, 8'd10, 11'd2047);
        send_pixel(8'd10, 8'd9, 8'd10, 8'd10, 11'd300);
        send_pixel(8'd12, 8'd13, 8'd10, 8'd10, 11'd1000);
        send_pixel(8'd0, 8'd128, 8'd255, 8'd128, 11'd2047);
        send_pixel(8'd40, 8'd40, 8'd41, 8'd41, 11'd1);
        send_pixel(8'd170, 8'd85, 8'd85, 8'd170, 11'd1365);
        send_pixel(8'd85, 8'd170, 8'd170, 8'd85, 11'd682);

        // Blur width zero: only the center keeps its level.
        set_blur_width(32'd0);
        send_pixel(8'd20, 8'd20, 8'd20, 8'd20, 11'd400);
        send_pixel(8'd21, 8'd20, 8'd20, 8'd20, 11'd2047);
        send_pixel(8'd21, 8'd21, 8'd20, 8'd20, 11'd2047);
        run_random(PHASE_ITEMS);

        // Widest blur and a blur of one, then assorted settings.
        set_blur_width(32'd255);
        send_pixel(8'd1, 8'd0, 8'd0, 8'd0, 11'd2047);
        send_pixel(8'd255, 8'd255, 8'd0, 8'd0, 11'd2047);
        run_random(PHASE_ITEMS);
        set_blur_width(32'd1);
        send_pixel(8'd1, 8'd0, 8'd0, 8'd0, 11'd2047);
        run_random(PHASE_ITEMS);
        set_blur_width(32'(($urandom & 32'hFFFF_FF00) | $urandom_range(1, 255)));
        run_random(PHASE_ITEMS);

        // A long stretch with no idle cycles.
        idle_on = 1'b0;
        set_blur_width(32'($urandom_range(1, 255)));
        run_random(PHASE_ITEMS);
        idle_on = 1'b1;

        set_blur_width(32'd2);
        run_random(PHASE_ITEMS);

        // A write beyond the only register must leave blur_width alone.
        set_blur_width(32'($urandom_range(1, 255)));
        apb_transfer(1'b1, ADDR_UNUSED, 32'($urandom_range(0, 255)));
        apb_transfer(1'b0, ADDR_BLUR_WIDTH, '0);
        run_random(PHASE_ITEMS);

        set_blur_width(32'd16);
        run_random(PHASE_ITEMS);

        // Wait for every color, then a few more cycles for strays.
        drain_colors();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("glow_dot_pixel_shader_unit: match");
        end else begin
            $display("glow_dot_pixel_shader_unit: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/gdps_pkg.sv
rtl/core/gdps_div_step.sv
rtl/core/glow_dot_pixel_shader_unit.sv
bench/gdps_color_checker.sv
bench/testbench.sv
